// ----- rtl/core/trke_pkg.sv -----
// Shared constants, codes and control structs for the toy RSA key generation block.
package trke_pkg;

  localparam int PRIME_WIDTH_DEF = 8;
  localparam int MSG_WIDTH_DEF   = 16;

  localparam int P_FIELD_W = 8;
  localparam int M_FIELD_W = 16;
  localparam int O_FIELD_W = 16;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTPRIME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOINV    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOW      = 2'd3;

  // multiplier operand select
  localparam logic [2:0] MS_II   = 3'd0;
  localparam logic [2:0] MS_PQ   = 3'd1;
  localparam logic [2:0] MS_PHI  = 3'd2;
  localparam logic [2:0] MS_PHIK = 3'd3;
  localparam logic [2:0] MS_SQ   = 3'd4;
  localparam logic [2:0] MS_AM   = 3'd5;

  // divider operand select
  localparam logic [1:0] DV_PT  = 2'd0;
  localparam logic [1:0] DV_GCD = 2'd1;
  localparam logic [1:0] DV_INV = 2'd2;
  localparam logic [1:0] DV_MOD = 2'd3;

  typedef struct packed {
    logic       load;
    logic       set_low;
    logic       set_notprime;
    logic       set_noinv;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       div_start;
    logic [1:0] div_sel;
    logic       pt_init;
    logic       pt_q;
    logic       i_inc;
    logic       n_ld;
    logic       phi_ld;
    logic       e_init;
    logic       e_inc;
    logic       g_init;
    logic       g_step;
    logic       k_init;
    logic       k_inc;
    logic       d_ld;
    logic       acc_init;
    logic       acc_ld;
    logic       bit_init;
    logic       bit_dec;
  } trke_cmd_t;

  typedef struct packed {
    logic low_in;
    logic pt_q;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic e_ge_phi;
    logic gy_zero;
    logic gx_one;
    logic k_gt_e;
    logic e_bit;
    logic bit_zero;
  } trke_sts_t;

endpackage

// ----- rtl/core/trke_in_if.sv -----
// Request channel carrying the two prime candidates and the message.
interface trke_in_if
  import trke_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [P_FIELD_W-1:0] prime_p;
  logic [P_FIELD_W-1:0] prime_q;
  logic [M_FIELD_W-1:0] message;

  modport source (output valid, output prime_p, output prime_q, output message, input ready);
  modport sink   (input valid, input prime_p, input prime_q, input message, output ready);
endinterface

// ----- rtl/core/trke_out_if.sv -----
// Result channel carrying the keys, the cipher and the status.
interface trke_out_if
  import trke_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [O_FIELD_W-1:0] modulus;
  logic [O_FIELD_W-1:0] totient;
  logic [O_FIELD_W-1:0] public_exp;
  logic [O_FIELD_W-1:0] private_exp;
  logic [O_FIELD_W-1:0] cipher;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, output modulus, output totient, output public_exp,
                  output private_exp, output cipher, output status, input ready);
  modport sink   (input valid, input modulus, input totient, input public_exp,
                  input private_exp, input cipher, input status, output ready);
endinterface

// ----- rtl/core/toy_rsa_keygen_encrypt.sv -----
// Top level of the toy RSA key generation and encryption block.
//
// Each request carries two prime candidates p and q and a message; the block
// answers with one result: modulus p*q, totient (p-1)*(q-1), the smallest
// public exponent e >= 2 coprime with the totient (2 if the totient is 2),
// the private exponent d (zero when none is found for k up to e, with status
// "no inverse" unless a candidate was found non-prime), and message^e mod
// modulus. Status reports ok, a non-prime candidate (keys are still computed),
// no inverse, or an input below two (all other fields zero). Only the low
// PRIME_WIDTH bits of each prime and MSG_WIDTH bits of the message are used;
// every result is truncated to 16 bits. One item is in work at a time. Its
// run time is set by the shared bit-serial divider, whose dividend is
// 2*max(2*PRIME_WIDTH, MSG_WIDTH) bits wide: it computes one remainder per
// trial divisor, per Euclid step of each exponent tried, per k of the inverse
// search, and one or two per exponent bit from the highest set bit down (a
// square, plus a multiply where the bit is set). A finished result waits in
// an output register, so the next request is taken while the previous result
// is still unread.
module toy_rsa_keygen_encrypt
  import trke_pkg::*;
#(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF,
  parameter int MSG_WIDTH   = MSG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  trke_in_if.sink           in_ch,
  trke_out_if.source        out_ch
);
  localparam int NW = 2 * PRIME_WIDTH;

  trke_cmd_t           cmd;
  trke_sts_t           sts;
  logic                out_load;
  logic                out_free;
  logic                in_ready;
  logic [NW-1:0]       res_n, res_phi, res_e, res_d, res_acc;
  logic [STATUS_W-1:0] res_status;

  logic                 out_valid_r;
  logic [O_FIELD_W-1:0] modulus_r, totient_r, public_exp_r, private_exp_r, cipher_r;
  logic [STATUS_W-1:0]  status_r;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  trke_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_load (out_load)
  );

  trke_dp #(.PRIME_WIDTH(PRIME_WIDTH), .MSG_WIDTH(MSG_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_p       (in_ch.prime_p),
    .in_q       (in_ch.prime_q),
    .in_msg     (in_ch.message),
    .sts        (sts),
    .res_n      (res_n),
    .res_phi    (res_phi),
    .res_e      (res_e),
    .res_d      (res_d),
    .res_acc    (res_acc),
    .res_status (res_status)
  );

  assign in_ch.ready = in_ready;

  // Hold the result until the sink takes it; drop valid on handoff.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      modulus_r     <= O_FIELD_W'(res_n);
      totient_r     <= O_FIELD_W'(res_phi);
      public_exp_r  <= O_FIELD_W'(res_e);
      private_exp_r <= O_FIELD_W'(res_d);
      cipher_r      <= O_FIELD_W'(res_acc);
      status_r      <= res_status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.modulus     = modulus_r;
  assign out_ch.totient     = totient_r;
  assign out_ch.public_exp  = public_exp_r;
  assign out_ch.private_exp = private_exp_r;
  assign out_ch.cipher      = cipher_r;
  assign out_ch.status      = status_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("waiting result overwritten");

  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_LOW) |->
      (out_ch.modulus == '0 && out_ch.cipher == '0 && out_ch.public_exp == '0))
    else $error("low-input result carries nonzero fields");
endmodule

// ----- rtl/core/trke_div.sv -----
// Restoring divider, one quotient bit per cycle.
module trke_div
  import trke_pkg::*;
#(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);
  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[DW-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule

// ----- rtl/core/trke_dp.sv -----
// Datapath: operand registers, shared multiplier and shared divider.
module trke_dp
  import trke_pkg::*;
#(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF,
  parameter int MSG_WIDTH   = MSG_WIDTH_DEF,
  localparam int PW = PRIME_WIDTH,
  localparam int NW = 2 * PRIME_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trke_cmd_t            cmd,
  input  logic [P_FIELD_W-1:0] in_p,
  input  logic [P_FIELD_W-1:0] in_q,
  input  logic [M_FIELD_W-1:0] in_msg,
  output trke_sts_t            sts,
  output logic [NW-1:0]        res_n,
  output logic [NW-1:0]        res_phi,
  output logic [NW-1:0]        res_e,
  output logic [NW-1:0]        res_d,
  output logic [NW-1:0]        res_acc,
  output logic [STATUS_W-1:0]  res_status
);
  localparam int MW  = MSG_WIDTH;
  localparam int OPW = (NW > MW) ? NW : MW;
  localparam int DW  = 2 * OPW;
  localparam int BW  = $clog2(NW);

  logic [PW-1:0]       p_r, q_r, i_r;
  logic [MW-1:0]       msg_r;
  logic                pt_q_r;
  logic [NW-1:0]       n_r, phi_r, e_r, gx_r, gy_r, d_r, acc_r;
  logic [NW:0]         k_r;
  logic [BW-1:0]       bit_r;
  logic [STATUS_W-1:0] status_r;
  logic [DW-1:0]       prod_r;

  logic [PW-1:0]  a_c;
  logic [OPW-1:0] ma, mb;
  logic [DW-1:0]  prod_c;
  logic [DW-1:0]  dvd;
  logic [NW-1:0]  dvs;
  logic           div_done;
  logic [DW-1:0]  div_quot;
  logic [NW-1:0]  div_rem;

  assign a_c = pt_q_r ? q_r : p_r;

  always_comb begin
    case (cmd.mul_sel)
      MS_II: begin
        ma = OPW'(i_r);
        mb = OPW'(i_r);
      end
      MS_PQ: begin
        ma = OPW'(p_r);
        mb = OPW'(q_r);
      end
      MS_PHI: begin
        ma = OPW'(PW'(p_r - 1'b1));
        mb = OPW'(PW'(q_r - 1'b1));
      end
      MS_PHIK: begin
        ma = OPW'(phi_r);
        mb = OPW'(k_r);
      end
      MS_SQ: begin
        ma = OPW'(acc_r);
        mb = OPW'(acc_r);
      end
      MS_AM: begin
        ma = OPW'(acc_r);
        mb = OPW'(msg_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_c = ma * mb;

  always_comb begin
    case (cmd.div_sel)
      DV_PT: begin
        dvd = DW'(a_c);
        dvs = NW'(i_r);
      end
      DV_GCD: begin
        dvd = DW'(gx_r);
        dvs = gy_r;
      end
      DV_INV: begin
        dvd = prod_r + DW'(1);
        dvs = e_r;
      end
      default: begin
        dvd = prod_r;
        dvs = n_r;
      end
    endcase
  end

  trke_div #(.DW(DW), .VW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r      <= PW'(in_p);
      q_r      <= PW'(in_q);
      msg_r    <= MW'(in_msg);
      n_r      <= '0;
      phi_r    <= '0;
      e_r      <= '0;
      d_r      <= '0;
      acc_r    <= '0;
      status_r <= ST_OK;
    end
    if (cmd.set_low)      status_r <= ST_LOW;
    if (cmd.set_notprime) status_r <= ST_NOTPRIME;
    if (cmd.set_noinv && status_r == ST_OK) status_r <= ST_NOINV;
    if (cmd.mul_en) prod_r <= prod_c;
    if (cmd.pt_init) begin
      pt_q_r <= cmd.pt_q;
      i_r    <= PW'(2);
    end
    if (cmd.i_inc)  i_r   <= i_r + 1'b1;
    if (cmd.n_ld)   n_r   <= prod_r[NW-1:0];
    if (cmd.phi_ld) phi_r <= prod_r[NW-1:0];
    if (cmd.e_init) e_r   <= NW'(2);
    if (cmd.e_inc)  e_r   <= e_r + 1'b1;
    if (cmd.g_init) begin
      gx_r <= e_r;
      gy_r <= phi_r;
    end
    if (cmd.g_step) begin
      gx_r <= gy_r;
      gy_r <= div_rem;
    end
    if (cmd.k_init)   k_r   <= (NW + 1)'(1);
    if (cmd.k_inc)    k_r   <= k_r + 1'b1;
    if (cmd.d_ld)     d_r   <= div_quot[NW-1:0];
    if (cmd.acc_init) acc_r <= NW'(1);
    if (cmd.acc_ld)   acc_r <= div_rem;
    if (cmd.bit_init) bit_r <= BW'(NW - 1);
    if (cmd.bit_dec)  bit_r <= bit_r - 1'b1;
  end

  assign sts.low_in   = (p_r < PW'(2)) || (q_r < PW'(2));
  assign sts.pt_q     = pt_q_r;
  assign sts.sq_gt    = prod_r > DW'(a_c);
  assign sts.div_done = div_done;
  assign sts.rem_zero = div_rem == '0;
  assign sts.e_ge_phi = e_r >= phi_r;
  assign sts.gy_zero  = gy_r == '0;
  assign sts.gx_one   = gx_r == NW'(1);
  assign sts.k_gt_e   = k_r > {1'b0, e_r};
  assign sts.e_bit    = e_r[bit_r];
  assign sts.bit_zero = bit_r == '0;

  assign res_n      = n_r;
  assign res_phi    = phi_r;
  assign res_e      = e_r;
  assign res_d      = d_r;
  assign res_acc    = acc_r;
  assign res_status = status_r;
endmodule

// ----- rtl/core/trke_ctrl.sv -----
// Controller: sequences prime test, exponent search, inverse search and exponentiation.
module trke_ctrl
  import trke_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  input  trke_sts_t sts,
  output trke_cmd_t cmd,
  output logic      in_ready,
  output logic      out_load
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_START  = 5'd1;
  localparam logic [4:0] S_PT_SQ  = 5'd2;
  localparam logic [4:0] S_PT_CHK = 5'd3;
  localparam logic [4:0] S_PT_DIV = 5'd4;
  localparam logic [4:0] S_N      = 5'd5;
  localparam logic [4:0] S_PHI    = 5'd6;
  localparam logic [4:0] S_E0     = 5'd7;
  localparam logic [4:0] S_E_CHK  = 5'd8;
  localparam logic [4:0] S_G_CHK  = 5'd9;
  localparam logic [4:0] S_G_DIV  = 5'd10;
  localparam logic [4:0] S_K_CHK  = 5'd11;
  localparam logic [4:0] S_K_MUL  = 5'd12;
  localparam logic [4:0] S_K_DIV  = 5'd13;
  localparam logic [4:0] S_XI     = 5'd14;
  localparam logic [4:0] S_X0     = 5'd15;
  localparam logic [4:0] S_X_SQ   = 5'd16;
  localparam logic [4:0] S_X_SQD  = 5'd17;
  localparam logic [4:0] S_X_SQW  = 5'd18;
  localparam logic [4:0] S_X_ML   = 5'd19;
  localparam logic [4:0] S_X_MLD  = 5'd20;
  localparam logic [4:0] S_X_MLW  = 5'd21;
  localparam logic [4:0] S_X_NX   = 5'd22;
  localparam logic [4:0] S_DONE   = 5'd23;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    out_load  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.low_in) begin
          cmd.set_low = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.pt_init = 1'b1;
          state_nxt   = S_PT_SQ;
        end
      end
      S_PT_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_II;
        state_nxt   = S_PT_CHK;
      end
      S_PT_CHK: begin
        if (sts.sq_gt) begin
          if (sts.pt_q) begin
            state_nxt = S_N;
          end else begin
            cmd.pt_init = 1'b1;
            cmd.pt_q    = 1'b1;
            state_nxt   = S_PT_SQ;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_PT;
          state_nxt     = S_PT_DIV;
        end
      end
      S_PT_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.set_notprime = 1'b1;
            state_nxt        = S_N;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = S_PT_SQ;
          end
        end
      end
      S_N: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PQ;
        state_nxt   = S_PHI;
      end
      S_PHI: begin
        cmd.n_ld    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PHI;
        state_nxt   = S_E0;
      end
      S_E0: begin
        cmd.phi_ld = 1'b1;
        cmd.e_init = 1'b1;
        state_nxt  = S_E_CHK;
      end
      S_E_CHK: begin
        if (sts.e_ge_phi) begin
          cmd.k_init = 1'b1;
          state_nxt  = S_K_CHK;
        end else begin
          cmd.g_init = 1'b1;
          state_nxt  = S_G_CHK;
        end
      end
      S_G_CHK: begin
        if (sts.gy_zero) begin
          if (sts.gx_one) begin
            cmd.k_init = 1'b1;
            state_nxt  = S_K_CHK;
          end else begin
            cmd.e_inc = 1'b1;
            state_nxt = S_E_CHK;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_GCD;
          state_nxt     = S_G_DIV;
        end
      end
      S_G_DIV: begin
        if (sts.div_done) begin
          cmd.g_step = 1'b1;
          state_nxt  = S_G_CHK;
        end
      end
      S_K_CHK: begin
        if (sts.k_gt_e) begin
          cmd.set_noinv = 1'b1;
          state_nxt     = S_XI;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_PHIK;
          state_nxt   = S_K_MUL;
        end
      end
      S_K_MUL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DV_INV;
        state_nxt     = S_K_DIV;
      end
      S_K_DIV: begin
        cmd.div_sel = DV_INV;
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.d_ld  = 1'b1;
            state_nxt = S_XI;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_K_CHK;
          end
        end
      end
      S_XI: begin
        cmd.acc_init = 1'b1;
        cmd.bit_init = 1'b1;
        state_nxt    = S_X0;
      end
      S_X0: begin
        if (sts.e_bit) begin
          state_nxt = S_X_SQ;
        end else begin
          cmd.bit_dec = 1'b1;
        end
      end
      S_X_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SQ;
        state_nxt   = S_X_SQD;
      end
      S_X_SQD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DV_MOD;
        state_nxt     = S_X_SQW;
      end
      S_X_SQW: begin
        cmd.div_sel = DV_MOD;
        if (sts.div_done) begin
          cmd.acc_ld = 1'b1;
          state_nxt  = sts.e_bit ? S_X_ML : S_X_NX;
        end
      end
      S_X_ML: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AM;
        state_nxt   = S_X_MLD;
      end
      S_X_MLD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DV_MOD;
        state_nxt     = S_X_MLW;
      end
      S_X_MLW: begin
        cmd.div_sel = DV_MOD;
        if (sts.div_done) begin
          cmd.acc_ld = 1'b1;
          state_nxt  = S_X_NX;
        end
      end
      S_X_NX: begin
        if (sts.bit_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.bit_dec = 1'b1;
          state_nxt   = S_X_SQ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
